// ===== src/sor_pkg.sv =====
// SOR solver package: sizes, operation, status and config codes, state encoding, saturation helper.
// No dependencies.
package sor_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned MaxDim = 16;
  localparam int unsigned IdxW   = $clog2(MaxDim);
  localparam int unsigned CntW   = $clog2(MaxDim + 1);

  localparam logic [1:0] OP_MAT   = 2'd0;
  localparam logic [1:0] OP_RHS   = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_RSVD  = 2'd3;

  localparam logic [1:0] ST_CONV  = 2'd0;
  localparam logic [1:0] ST_LIMIT = 2'd1;
  localparam logic [1:0] ST_ZDIAG = 2'd2;

  localparam logic [1:0] CFG_DIM  = 2'd0;
  localparam logic [1:0] CFG_W    = 2'd1;
  localparam logic [1:0] CFG_TOL  = 2'd2;
  localparam logic [1:0] CFG_LIM  = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DCHK,   // diagonal scan
    S_RSTRT,  // row start: issue diag/rhs reads
    S_MAC,    // off-diagonal products
    S_RES,    // residual
    S_DIV,    // restoring divide
    S_BLND,   // blend multiply
    S_WB,     // write back, convergence check
    S_SWEND,  // end of sweep
    S_OUT     // emit results
  } state_t;

  // Saturate 64-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647)       return 32'sh7fffffff;
    else if (v < -64'sd2147483648) return 32'sh80000000;
    else                           return v[31:0];
  endfunction

endpackage

// ===== src/sor_div.sv =====
// Iterative signed divider, one quotient bit per cycle, truncates toward zero.
// Depends on sor_pkg.
module sor_div
  import sor_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               go,
  input  logic signed [47:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [48:0] quo
);
  logic [47:0] q_r, q_nxt;
  logic [48:0] rem_r, rem_nxt;
  logic [31:0] d_r;
  logic        neg_r, busy_r;
  logic [5:0]  cnt_r;
  logic [48:0] trial;
  logic [47:0] un;

  assign un = num[47] ? 48'(-num) : 48'(num);
  assign trial = {rem_r[47:0], q_r[47]} - {17'd0, d_r};

  always_comb begin
    q_nxt   = {q_r[46:0], 1'b0};
    rem_nxt = {rem_r[47:0], q_r[47]};
    if (!trial[48]) begin
      rem_nxt = trial;
      q_nxt[0] = 1'b1;
    end
  end

  // 48 quotient steps, then one cycle with done high
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (go) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'd48;
      q_r    <= un;
      rem_r  <= '0;
      d_r    <= den[31] ? 32'(-den) : 32'(den);
      neg_r  <= num[47] ^ den[31];
    end else if (busy_r) begin
      if (cnt_r != 6'd0) begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 6'd1;
      end else begin
        busy_r <= 1'b0;
      end
    end
  end

  assign done = busy_r && (cnt_r == 6'd0);
  assign quo  = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

endmodule

// ===== src/sor_mem.sv =====
// Storage: matrix RAM (256x32) and vector RAM (rhs only).
// Synchronous read, data returned in the cycle after the address. Depends on sor_pkg.
module sor_mem
  import sor_pkg::*;
(
  input  logic                   clk,
  input  logic                   m_we,
  input  logic [2*IdxW-1:0]      m_waddr,
  input  logic [DataW-1:0]       m_wdata,
  input  logic [2*IdxW-1:0]      m_raddr,
  output logic [DataW-1:0]       m_rdata,
  input  logic                   b_we,
  input  logic [IdxW-1:0]        b_waddr,
  input  logic [DataW-1:0]       b_wdata,
  input  logic [IdxW-1:0]        b_raddr,
  output logic [DataW-1:0]       b_rdata
);
  logic [DataW-1:0] mat [MaxDim*MaxDim];
  logic [DataW-1:0] rhs [MaxDim];

  always_ff @(posedge clk) begin
    if (m_we) mat[m_waddr] <= m_wdata;
    m_rdata <= mat[m_raddr];
  end

  always_ff @(posedge clk) begin
    if (b_we) rhs[b_waddr] <= b_wdata;
    b_rdata <= rhs[b_raddr];
  end
endmodule

// ===== src/sor_linear_solver.sv =====
// SOR solver top level: control sequencer, estimate register file, datapath.
// Depends on sor_pkg, sor_mem, sor_div.
//
// Load transfers (matrix or rhs entry) never assert busy. A start transfer
// holds busy through the whole solve: a diagonal scan (one read and one check
// per row) and a sweep-end step, then per sweep n rows (each a row-start
// step, matrix reads through the single read port of the matrix RAM, a
// residual step, a divide of 48 quotient steps and a done strobe, a blend
// multiply and a write back), plus a sweep-end step per sweep. The n results
// then leave one per cycle, each marked by out_valid for one cycle; the
// receiver cannot stall, so it must take every transfer as it comes.
// Estimates live in a small register file, cleared at every start.
module sor_linear_solver
  import sor_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic [3:0]         in_row,
  input  logic [3:0]         in_col,
  input  logic signed [31:0] in_value,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_wdata,
  output logic               out_valid,
  output logic [3:0]         out_element_index,
  output logic signed [31:0] out_solution_value,
  output logic [1:0]         out_status,
  output logic [15:0]        out_iterations,
  output logic               out_last_element
);
  // configuration
  logic [4:0]  dim_r;
  logic [16:0] w_r;
  logic [15:0] tol_r, lim_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= 5'd16; w_r <= 17'd58982; tol_r <= 16'd1; lim_r <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIM: dim_r <= cfg_wdata[4:0];
        CFG_W:   w_r   <= cfg_wdata;
        CFG_TOL: tol_r <= cfg_wdata[15:0];
        CFG_LIM: lim_r <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  logic [CntW-1:0] n_used;
  always_comb begin
    if (dim_r == 5'd0) n_used = CntW'(1);
    else if (32'(dim_r) > MaxDim) n_used = CntW'(MaxDim);
    else n_used = CntW'(dim_r);
  end

  logic load_ok;
  assign load_ok = start && !busy && (32'(in_row) < MaxDim) &&
                   (in_operation == OP_RHS || 32'(in_col) < MaxDim);

  // state
  state_t st_r, st_nxt;
  logic [IdxW-1:0] i_r, j_r;
  logic [IdxW-1:0] i_nxt, j_nxt;
  logic jv_r;           // a matrix read of column jd_r is returning
  logic jv_nxt;
  logic [IdxW-1:0] jd_r;
  logic signed [63:0] sum_r;
  logic signed [31:0] diag_r, rhs_r, quot_r;
  logic signed [63:0] blend_r;
  logic [15:0] sweep_r;
  logic [1:0]  stat_r;
  logic        settled_r, zd_r, first_r;
  logic signed [31:0] x_r [MaxDim];
  logic signed [31:0] xp_r [MaxDim];

  // memories
  logic m_we;
  logic [2*IdxW-1:0] m_waddr, m_raddr;
  logic [31:0] m_rdata, b_rdata;
  logic b_we;
  logic [IdxW-1:0] b_raddr;

  assign m_we    = load_ok && in_operation == OP_MAT;
  assign m_waddr = {in_row[IdxW-1:0], in_col[IdxW-1:0]};
  assign b_we    = load_ok && in_operation == OP_RHS;

  always_comb begin
    m_raddr = {i_r, j_r};
    if (st_r == S_DCHK || st_r == S_RSTRT) m_raddr = {i_r, i_r};
  end
  assign b_raddr = i_r;

  sor_mem u_mem (
    .clk, .m_we, .m_waddr, .m_wdata(in_value), .m_raddr, .m_rdata,
    .b_we, .b_waddr(in_row[IdxW-1:0]), .b_wdata(in_value), .b_raddr, .b_rdata
  );

  // residual feeds the divider directly in S_RES
  logic signed [31:0] resid_c;
  assign resid_c = sat32(64'(rhs_r) - sum_r);

  // divider
  logic div_go, div_done;
  logic signed [48:0] div_q;
  assign div_go = (st_r == S_RES);
  sor_div u_div (
    .clk, .rst_n, .go(div_go), .num({resid_c, 16'd0}), .den(diag_r),
    .done(div_done), .quo(div_q)
  );

  logic last_i;
  assign last_i = (CntW'(i_r) == n_used - CntW'(1));
  logic last_j;
  assign last_j = (CntW'(j_r) == n_used - CntW'(1));

  logic is_start;
  assign is_start = start && !busy && in_operation == OP_START;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:  if (is_start) st_nxt = S_DCHK;
      S_DCHK:  if (jv_r && jd_r == i_r && last_i) st_nxt = S_SWEND;
      S_RSTRT: st_nxt = S_MAC;
      S_MAC:   if (jv_r && jd_r == j_r && last_j) st_nxt = S_RES;
      S_RES:   st_nxt = S_DIV;
      S_DIV:   if (div_done) st_nxt = S_BLND;
      S_BLND:  st_nxt = S_WB;
      S_WB:    st_nxt = last_i ? S_SWEND : S_RSTRT;
      S_SWEND: st_nxt = S_OUT;
      S_OUT:   if (last_i) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
    if (st_r == S_SWEND && !zd_r && !(first_r ? 1'b0 : settled_r) &&
        sweep_r != lim_r) st_nxt = S_RSTRT;
  end

  always_comb begin
    i_nxt = i_r; j_nxt = j_r; jv_nxt = 1'b0;
    case (st_r)
      S_IDLE:  if (is_start) begin
        i_nxt = '0; j_nxt = '0;
      end
      S_DCHK:  begin
        jv_nxt = !jv_r;
        if (jv_r && !last_i) i_nxt = i_r + IdxW'(1);
      end
      S_RSTRT: j_nxt = '0;
      S_MAC:   begin
        jv_nxt = !(jv_r && jd_r == j_r);
        if (!last_j) j_nxt = j_r + IdxW'(1);
      end
      S_WB:    if (!last_i) i_nxt = i_r + IdxW'(1);
      S_SWEND: i_nxt = '0;
      S_OUT:   i_nxt = i_r + IdxW'(1);
      default: ;
    endcase
  end

  logic signed [63:0] prod;
  logic signed [31:0] xj;
  assign xj   = x_r[jd_r];
  assign prod = $signed(m_rdata) * xj;

  logic signed [31:0] xnew;
  assign xnew = sat32(blend_r >>> 16);
  logic signed [32:0] dlt;
  logic [32:0] adlt;
  assign dlt  = 33'(xnew) - 33'(xp_r[i_r]);
  assign adlt = dlt[32] ? 33'(-dlt) : 33'(dlt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; i_r <= '0; j_r <= '0; jv_r <= 1'b0;
      sweep_r <= '0; stat_r <= ST_CONV; zd_r <= 1'b0; settled_r <= 1'b1;
      first_r <= 1'b1;
    end else begin
      st_r <= st_nxt; i_r <= i_nxt; j_r <= j_nxt; jv_r <= jv_nxt;
      case (st_r)
        S_IDLE: if (is_start) begin
          sweep_r <= '0; zd_r <= 1'b0;
          first_r <= 1'b1; settled_r <= 1'b1;
          for (int k = 0; k < MaxDim; k++) begin
            x_r[k] <= '0; xp_r[k] <= '0;
          end
        end
        S_DCHK: begin
          jd_r <= i_r;
          if (jv_r && m_rdata == 32'd0) zd_r <= 1'b1;
        end
        S_RSTRT: begin
          sum_r <= '0;
        end
        S_MAC: begin
          jd_r <= j_r;
          if (jv_r && jd_r == i_r) diag_r <= m_rdata;
          else if (jv_r) sum_r <= sum_r + (prod >>> 16);
          if (!jv_r) rhs_r <= b_rdata;
        end
        S_DIV: if (div_done) quot_r <= sat32(64'(div_q));
        S_BLND: blend_r <= $signed(18'h10000 - {1'b0, w_r}) * xp_r[i_r] +
                           $signed({1'b0, w_r}) * quot_r;
        S_WB: begin
          x_r[i_r] <= xnew;
          if (!(adlt < 33'(tol_r))) settled_r <= 1'b0;
        end
        S_SWEND: begin
          if (zd_r) stat_r <= ST_ZDIAG;
          else if (!first_r && settled_r) stat_r <= ST_CONV;
          else if (sweep_r == lim_r) stat_r <= ST_LIMIT;
          else begin
            for (int k = 0; k < MaxDim; k++) xp_r[k] <= x_r[k];
          end
          if (!zd_r && !(!first_r && settled_r) && sweep_r != lim_r) begin
            sweep_r <= sweep_r + 16'd1; settled_r <= 1'b1; first_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign busy = (st_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= (st_r == S_OUT);
    out_element_index  <= 4'(i_r);
    out_solution_value <= zd_r ? 32'sd0 : x_r[i_r];
    out_status         <= stat_r;
    out_iterations     <= sweep_r;
    out_last_element   <= last_i;
  end

  a_out_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_OUT) |-> busy) else $error("emit while idle");
  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_RSTRT) |-> (sweep_r <= lim_r)) else $error("sweep past limit");
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !m_we && !b_we) else $error("store write during solve");
endmodule
